[hw/rtl/pdx_pkg.sv]
package pdx_pkg;

   // body buffer depth, 1 to 64
   localparam int BODY_DEPTH = 32;
   localparam int ADDR_W     = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
   localparam int CNT_W      = 6;
   localparam int BYTE_W     = 8;
   localparam int TMO_W      = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] DEPTH_BYTE = BYTE_W'(BODY_DEPTH);
   localparam logic [TMO_W-1:0]  TIMEOUT_MAX = 24'hFF_FFFF;

   localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h55;
   localparam logic [CNT_W-1:0]  MAXB_RESET  = 6'd32;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_IDLE = 1'b1;

   localparam logic KIND_BODY = 1'b0;
   localparam logic KIND_ERR  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START   = 2'd0,
      CSR_STOP    = 2'd1,
      CSR_MAXBODY = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_SIZE = 3'd1,
      PH_TYPE = 3'd2,
      PH_BODY = 3'd3,
      PH_STOP = 3'd4,
      PH_CSUM = 3'd5
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] stop_byte;
      logic [CNT_W-1:0]  max_body;
      logic [TMO_W-1:0]  timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // run request from the parser to the emitter
   typedef struct packed {
      logic              start;
      logic              good;
      logic [CNT_W-1:0]  length;
      logic [BYTE_W-1:0] mtype;
   } emit_cmd_type;

endpackage

[hw/rtl/pdx_body_ram.sv]
module pdx_body_ram (
   input  logic                             clock,
   input  pdx_pkg::ram_wr_type              wr,
   input  pdx_pkg::ram_rd_type              rd,
   output logic [pdx_pkg::BYTE_W-1:0]       rd_data
);

   logic [pdx_pkg::BYTE_W-1:0] mem [pdx_pkg::BODY_DEPTH];
   logic [pdx_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pdx_frame_fsm.sv]
module pdx_frame_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          command,
   input  logic [pdx_pkg::BYTE_W-1:0]    rx_byte,
   input  pdx_pkg::cfg_type              cfg,
   output pdx_pkg::ram_wr_type           ram_wr,
   output pdx_pkg::emit_cmd_type         emit_cmd
);

   pdx_pkg::phase_type phase_ff, phase_in;
   logic [pdx_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic [pdx_pkg::CNT_W-1:0]  len_ff, len_in;
   logic [pdx_pkg::BYTE_W-1:0] type_ff, type_in;
   logic [pdx_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pdx_pkg::TMO_W-1:0]  idle_ff, idle_in;

   logic [pdx_pkg::TMO_W-1:0]  idle_inc;
   logic [pdx_pkg::TMO_W-1:0]  idle_lim;
   logic                       idle_abort;
   logic [pdx_pkg::BYTE_W-1:0] body_lim;
   logic                       size_bad;
   logic [pdx_pkg::CNT_W-1:0]  count_inc;
   logic                       is_start;
   logic                       is_stop;

   assign idle_inc   = idle_ff + 1'b1;
   assign idle_lim   = (cfg.timeout_ticks == '0) ? pdx_pkg::TMO_W'(1) : cfg.timeout_ticks;
   assign idle_abort = (idle_inc >= idle_lim);
   assign body_lim   = ({2'b00, cfg.max_body} > pdx_pkg::DEPTH_BYTE) ? pdx_pkg::DEPTH_BYTE
                                                                   : {2'b00, cfg.max_body};
   assign size_bad   = (rx_byte == '0) || (rx_byte > body_lim);
   assign count_inc  = count_ff + 1'b1;
   assign is_start   = (rx_byte == cfg.start_byte);
   assign is_stop    = (rx_byte == cfg.stop_byte);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (command == pdx_pkg::CMD_IDLE) begin
            unique case (phase_ff)
               pdx_pkg::PH_SIZE, pdx_pkg::PH_TYPE, pdx_pkg::PH_BODY,
               pdx_pkg::PH_STOP, pdx_pkg::PH_CSUM: begin
                  if (idle_abort) phase_in = pdx_pkg::PH_HUNT;
               end
               default: phase_in = pdx_pkg::PH_HUNT;
            endcase
         end else begin
            unique case (phase_ff)
               pdx_pkg::PH_SIZE: phase_in = size_bad ? pdx_pkg::PH_HUNT : pdx_pkg::PH_TYPE;
               pdx_pkg::PH_TYPE: phase_in = pdx_pkg::PH_BODY;
               pdx_pkg::PH_BODY: begin
                  if (count_inc >= len_ff) phase_in = pdx_pkg::PH_STOP;
               end
               pdx_pkg::PH_STOP: phase_in = is_stop ? pdx_pkg::PH_CSUM : pdx_pkg::PH_HUNT;
               pdx_pkg::PH_CSUM: phase_in = pdx_pkg::PH_HUNT;
               default: phase_in = is_start ? pdx_pkg::PH_SIZE : pdx_pkg::PH_HUNT;
            endcase
         end
      end
   end

   // datapath and outputs
   always_comb begin
      xor_in          = xor_ff;
      len_in          = len_ff;
      type_in         = type_ff;
      count_in        = count_ff;
      idle_in         = idle_ff;
      ram_wr.en       = 1'b0;
      ram_wr.addr     = count_ff[pdx_pkg::ADDR_W-1:0];
      ram_wr.data     = rx_byte;
      emit_cmd.start  = 1'b0;
      emit_cmd.good   = (xor_ff == rx_byte);
      emit_cmd.length = len_ff;
      emit_cmd.mtype  = type_ff;
      if (accept) begin
         if (command == pdx_pkg::CMD_IDLE) begin
            unique case (phase_ff)
               pdx_pkg::PH_SIZE, pdx_pkg::PH_TYPE, pdx_pkg::PH_BODY,
               pdx_pkg::PH_STOP, pdx_pkg::PH_CSUM: begin
                  if (idle_abort) begin
                     xor_in   = '0;
                     count_in = '0;
                     idle_in  = '0;
                  end else begin
                     idle_in  = idle_inc;
                  end
               end
               default: begin
                  xor_in   = '0;
                  count_in = '0;
                  idle_in  = '0;
               end
            endcase
         end else begin
            idle_in = '0;
            unique case (phase_ff)
               pdx_pkg::PH_SIZE: begin
                  if (size_bad) begin
                     xor_in   = '0;
                     count_in = '0;
                  end else begin
                     len_in = rx_byte[pdx_pkg::CNT_W-1:0];
                     xor_in = xor_ff ^ rx_byte;
                  end
               end
               pdx_pkg::PH_TYPE: begin
                  type_in  = rx_byte;
                  xor_in   = xor_ff ^ rx_byte;
                  count_in = '0;
               end
               pdx_pkg::PH_BODY: begin
                  ram_wr.en = 1'b1;
                  count_in  = count_inc;
                  xor_in    = xor_ff ^ rx_byte;
               end
               pdx_pkg::PH_STOP: begin
                  if (is_stop) begin
                     xor_in = xor_ff ^ rx_byte;
                  end else begin
                     xor_in   = '0;
                     count_in = '0;
                  end
               end
               pdx_pkg::PH_CSUM: begin
                  emit_cmd.start = 1'b1;
                  xor_in         = '0;
                  count_in       = '0;
               end
               default: begin
                  xor_in   = is_start ? rx_byte : '0;
                  count_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pdx_pkg::PH_HUNT;
         xor_ff   <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         count_ff <= '0;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         count_ff <= count_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

[hw/rtl/pdx_emit_unit.sv]
module pdx_emit_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  pdx_pkg::emit_cmd_type         emit_cmd,
   output pdx_pkg::ram_rd_type           ram_rd,
   input  logic [pdx_pkg::BYTE_W-1:0]    ram_data,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_out_kind,
   output logic [pdx_pkg::BYTE_W-1:0]    rsp_body_byte,
   output logic [pdx_pkg::BYTE_W-1:0]    rsp_message_type,
   output logic [pdx_pkg::CNT_W-1:0]     rsp_body_length,
   output logic                          rsp_last_of_run
);

   logic                       active_ff, active_in;
   logic [pdx_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [pdx_pkg::CNT_W-1:0]  len_ff, len_in;
   logic [pdx_pkg::BYTE_W-1:0] mtype_ff, mtype_in;
   logic                       pend_ff, pend_in;
   logic                       pend_err_ff, pend_err_in;
   logic                       pend_last_ff, pend_last_in;
   logic                       valid_ff, valid_in;
   logic                       kind_ff, kind_in;
   logic [pdx_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [pdx_pkg::BYTE_W-1:0] otype_ff, otype_in;
   logic [pdx_pkg::CNT_W-1:0]  olen_ff, olen_in;
   logic                       olast_ff, olast_in;

   logic                       load;
   logic                       issue;
   logic [pdx_pkg::CNT_W-1:0]  idx_inc;

   assign load    = pend_ff && (!valid_ff || rsp_ready);
   assign issue   = active_ff && (!pend_ff || load);
   assign idx_inc = idx_ff + 1'b1;

   assign ram_rd.en   = issue;
   assign ram_rd.addr = idx_ff[pdx_pkg::ADDR_W-1:0];
   assign busy        = active_ff || pend_ff;

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      mtype_in     = mtype_ff;
      pend_in      = pend_ff;
      pend_err_in  = pend_err_ff;
      pend_last_in = pend_last_ff;
      if (emit_cmd.start) begin
         len_in   = emit_cmd.length;
         mtype_in = emit_cmd.mtype;
         idx_in   = '0;
         if (emit_cmd.good) begin
            active_in = 1'b1;
         end else begin
            pend_in      = 1'b1;
            pend_err_in  = 1'b1;
            pend_last_in = 1'b1;
         end
      end else if (issue) begin
         idx_in       = idx_inc;
         active_in    = (idx_inc != len_ff);
         pend_in      = 1'b1;
         pend_err_in  = 1'b0;
         pend_last_in = (idx_inc == len_ff);
      end else if (load) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      otype_in = otype_ff;
      olen_in  = olen_ff;
      olast_in = olast_ff;
      if (load) begin
         valid_in = 1'b1;
         kind_in  = pend_err_ff ? pdx_pkg::KIND_ERR : pdx_pkg::KIND_BODY;
         byte_in  = pend_err_ff ? '0 : ram_data;
         otype_in = mtype_ff;
         olen_in  = len_ff;
         olast_in = pend_last_ff;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      mtype_ff     <= mtype_in;
      pend_err_ff  <= pend_err_in;
      pend_last_ff <= pend_last_in;
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      otype_ff     <= otype_in;
      olen_ff      <= olen_in;
      olast_ff     <= olast_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_kind     = kind_ff;
   assign rsp_body_byte    = byte_ff;
   assign rsp_message_type = otype_ff;
   assign rsp_body_length  = olen_ff;
   assign rsp_last_of_run  = olast_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff < len_ff))
      else $error("read index past frame length");

   a_issue_fills: assert property (@(posedge clock) disable iff (reset)
      issue |=> pend_ff)
      else $error("issued read not marked pending");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      emit_cmd.start |-> (!active_ff && !pend_ff))
      else $error("new run while previous run in flight");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && pend_err_ff) |-> pend_last_ff)
      else $error("error beat not flagged last");

endmodule

[hw/rtl/packet_deframer_xor_checksum_core.sv]
// channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// request   | req_valid/req_ready, req_command,       | in
//           | req_rx_byte                             |
// response  | rsp_valid/rsp_ready, rsp_out_kind,      | out
//           | rsp_body_byte, rsp_message_type,        |
//           | rsp_body_length, rsp_last_of_run        |
// csr       | csr_we, csr_index, csr_wdata            | in
//
// One request beat per cycle while no run is in flight.
// A good CHECK starts a run of body_length beats read from the body RAM: the emitter
// goes active, reads the RAM, then registers each beat; one per cycle while rsp_ready is high.
// A bad CHECK gives one error beat, passed from the pending register to the response register.
// req_ready is low from the CHECK edge until the last beat is loaded.
// Synchronous reset clears control state; the body RAM is never read unwritten.
module packet_deframer_xor_checksum_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [pdx_pkg::BYTE_W-1:0]           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_out_kind,
   output logic [pdx_pkg::BYTE_W-1:0]           rsp_body_byte,
   output logic [pdx_pkg::BYTE_W-1:0]           rsp_message_type,
   output logic [pdx_pkg::CNT_W-1:0]            rsp_body_length,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_we,
   input  logic [pdx_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pdx_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   pdx_pkg::cfg_type      cfg_ff, cfg_in;
   pdx_pkg::ram_wr_type   ram_wr;
   pdx_pkg::ram_rd_type   ram_rd;
   pdx_pkg::emit_cmd_type emit_cmd;
   logic [pdx_pkg::BYTE_W-1:0] ram_data;
   logic                  busy;
   logic                  accept;

   // config registers; the user writes them only while no frame is in flight, unchecked by the block
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (pdx_pkg::csr_index_type'(csr_index))
            pdx_pkg::CSR_START:   cfg_in.start_byte    = csr_wdata[pdx_pkg::BYTE_W-1:0];
            pdx_pkg::CSR_STOP:    cfg_in.stop_byte     = csr_wdata[pdx_pkg::BYTE_W-1:0];
            pdx_pkg::CSR_MAXBODY: cfg_in.max_body      = csr_wdata[pdx_pkg::CNT_W-1:0];
            pdx_pkg::CSR_TIMEOUT: cfg_in.timeout_ticks = csr_wdata[pdx_pkg::TMO_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= pdx_pkg::START_RESET;
         cfg_ff.stop_byte     <= pdx_pkg::STOP_RESET;
         cfg_ff.max_body      <= pdx_pkg::MAXB_RESET;
         cfg_ff.timeout_ticks <= pdx_pkg::TIMEOUT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake stalls only while a run drains
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   pdx_frame_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (req_command),
      .rx_byte  (req_rx_byte),
      .cfg      (cfg_ff),
      .ram_wr   (ram_wr),
      .emit_cmd (emit_cmd)
   );

   pdx_body_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_data)
   );

   pdx_emit_unit u_emit (
      .clock            (clock),
      .reset            (reset),
      .emit_cmd         (emit_cmd),
      .ram_rd           (ram_rd),
      .ram_data         (ram_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_message_type (rsp_message_type),
      .rsp_body_length  (rsp_body_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
